// ----- src/fpb_pkg.sv -----
// Shared types, constants and codes for the finder pattern band classifier.
package fpb_pkg;

  localparam int LANES           = 5;
  localparam int WIN             = 5;
  localparam int PIX_W           = 8;
  localparam int RUN_W           = 8;
  localparam int SEEN_W          = 3;
  localparam int CNT_W           = 8;
  localparam int MAX_LINE_LENGTH = 64;
  localparam int VOTE_MIN        = 3;

  // Window sum, pattern-scaled terms, error sum and the final compare width.
  localparam int SUM_W  = 11;
  localparam int TERM_W = 13;
  localparam int ERR_W  = 15;
  localparam int CMP_W  = 18;

  localparam logic [RUN_W-1:0]  RUN_MAX  = '1;
  localparam logic [SEEN_W-1:0] SEEN_MAX = '1;
  localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

  typedef logic [2:0] pat_t [WIN];
  localparam pat_t PAT_NORMAL = '{3'd1, 3'd1, 3'd4, 3'd1, 3'd1};
  localparam pat_t PAT_BR     = '{3'd1, 3'd2, 3'd2, 3'd2, 3'd1};

  typedef enum logic [1:0] {
    TYPE_NONE   = 2'd0,
    TYPE_NORMAL = 2'd1,
    TYPE_CORNER = 2'd2
  } anchor_t;

  typedef enum logic [1:0] {
    CAUSE_OK       = 2'd0,
    CAUSE_DISAGREE = 2'd1,
    CAUSE_FEW_RUNS = 2'd2,
    CAUSE_VOTE     = 2'd3
  } cause_t;

  typedef logic [WIN-1:0][RUN_W-1:0] window_t;

  // End-of-line bookkeeping that rides with each beat.
  typedef struct packed {
    logic [LANES-1:0] check;
    logic             last;
    logic             few_runs;
    logic [CNT_W-1:0] dis;
    logic [CNT_W-1:0] pos;
  } fpb_meta_t;

  // One beat from the front to the back: windows to test plus bookkeeping.
  typedef struct packed {
    window_t [LANES-1:0] win;
    fpb_meta_t           meta;
  } fpb_beat_t;

endpackage

// ----- src/fpb_front.sv -----
// Front end: binarize, run-length encode each lane and shift runs into the windows.
module fpb_front (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      accept,
  input  logic [fpb_pkg::LANES-1:0][fpb_pkg::PIX_W-1:0] pixel,
  input  logic                                      last_sample,
  output fpb_pkg::fpb_beat_t                        beat
);
  import fpb_pkg::*;

  logic [LANES-1:0]               color, color_next;
  logic [LANES-1:0][RUN_W-1:0]    run_len, run_len_next;
  logic [LANES-1:0][SEEN_W-1:0]   seen, seen_next;
  window_t [LANES-1:0]            win, win_next;
  logic [LANES-1:0][WIN-1:0]      wcol, wcol_next;
  logic [CNT_W-1:0]               dis, dis_next;
  logic [CNT_W-1:0]               pos, pos_next;

  logic [LANES-1:0] col;
  logic [LANES-1:0] push;
  logic [LANES-1:0] check;
  logic             diff;
  logic             last;
  logic             few_runs;

  always_comb begin
    logic [RUN_W-1:0] plen;
    logic             pcol;
    last     = last_sample || (pos >= CNT_W'(MAX_LINE_LENGTH - 1));
    diff     = 1'b0;
    few_runs = 1'b0;
    for (int j = 0; j < LANES; j++) begin
      col[j]          = pixel[j][PIX_W-1];
      if (col[j] != col[0]) diff = 1'b1;
      push[j]         = 1'b0;
      plen            = run_len[j];
      pcol            = color[j];
      color_next[j]   = color[j];
      run_len_next[j] = run_len[j];
      if (pos == '0) begin
        color_next[j]   = col[j];
        run_len_next[j] = RUN_W'(1);
      end else if (col[j] == color[j]) begin
        run_len_next[j] = (run_len[j] != RUN_MAX) ? run_len[j] + RUN_W'(1) : run_len[j];
        // Close the open run at end of line unless it is a single pixel.
        if (last && run_len_next[j] > RUN_W'(1)) begin
          push[j] = 1'b1;
          plen    = run_len_next[j];
        end
      end else begin
        push[j]         = 1'b1;
        run_len_next[j] = RUN_W'(1);
        color_next[j]   = col[j];
      end

      win_next[j]  = win[j];
      wcol_next[j] = wcol[j];
      seen_next[j] = seen[j];
      if (push[j]) begin
        for (int k = 0; k < WIN - 1; k++) begin
          win_next[j][k]  = win[j][k+1];
          wcol_next[j][k] = wcol[j][k+1];
        end
        win_next[j][WIN-1]  = plen;
        wcol_next[j][WIN-1] = pcol;
        if (seen[j] != SEEN_MAX) seen_next[j] = seen[j] + SEEN_W'(1);
      end
      check[j] = push[j] && (seen_next[j] >= SEEN_W'(WIN)) && wcol_next[j][0];
      if (seen_next[j] < SEEN_W'(WIN)) few_runs = 1'b1;
    end
    dis_next = (diff && dis != CNT_MAX) ? dis + CNT_W'(1) : dis;
    pos_next = (pos != CNT_MAX) ? pos + CNT_W'(1) : pos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      color   <= '0;
      run_len <= '0;
      seen    <= '0;
      dis     <= '0;
      pos     <= '0;
    end else if (accept) begin
      if (last) begin
        // Line done: start the next one from scratch.
        color   <= '0;
        run_len <= '0;
        seen    <= '0;
        dis     <= '0;
        pos     <= '0;
      end else begin
        color   <= color_next;
        run_len <= run_len_next;
        seen    <= seen_next;
        dis     <= dis_next;
        pos     <= pos_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      win  <= win_next;
      wcol <= wcol_next;
    end
  end

  always_comb begin
    beat.win           = win_next;
    beat.meta.check    = check;
    beat.meta.last     = last;
    beat.meta.few_runs = few_runs;
    beat.meta.dis      = dis_next;
    beat.meta.pos      = pos_next;
  end

endmodule

// ----- src/fpb_queue.sv -----
// Short beat queue between the front end and the match pipeline.
module fpb_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  fpb_pkg::fpb_beat_t wr_data,
  output logic               full,
  input  logic               rd_en,
  output fpb_pkg::fpb_beat_t rd_data,
  output logic               avail
);
  import fpb_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  fpb_beat_t        mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W:0]   count;

  assign full    = (count == (PTR_W + 1)'(DEPTH));
  assign avail   = (count != '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= wr_ptr + PTR_W'(1);
      if (rd_en) rd_ptr <= rd_ptr + PTR_W'(1);
      if (wr_en && !rd_en)      count <= count + (PTR_W + 1)'(1);
      else if (rd_en && !wr_en) count <= count - (PTR_W + 1)'(1);
    end
  end

endmodule

// ----- src/fpb_back.sv -----
// Back end: ratio test pipeline, per-lane found type and the line decision.
module fpb_back (
  input  logic               clk,
  input  logic               rst,
  input  fpb_pkg::fpb_beat_t q_data,
  input  logic               q_avail,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         anchor_type,
  output logic [1:0]         reject_cause
);
  import fpb_pkg::*;

  logic en;

  // Stage A: window sums.
  logic                           va;
  fpb_meta_t                      meta_a;
  window_t [LANES-1:0]            win_a;
  logic [LANES-1:0][SUM_W-1:0]    sum_a, sum_next;

  // Stage B: absolute error terms for both patterns.
  logic                                va_b;
  fpb_meta_t                           meta_b;
  logic [LANES-1:0][SUM_W-1:0]         sum_b;
  logic [LANES-1:0][WIN-1:0][TERM_W-1:0] tn_b, tb_b, tn_next, tb_next;

  // Stage C: match flags.
  logic              vc;
  fpb_meta_t         meta_c;
  logic              dis_c, dis_next;
  logic [LANES-1:0]  mn_c, mb_c, mn_next, mb_next;

  anchor_t           found [LANES];
  anchor_t           found_eff [LANES];
  anchor_t           anchor_next;
  cause_t            cause_next;

  assign en    = !out_valid || !out_stall;
  assign q_pop = en && q_avail;

  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      sum_next[j] = '0;
      for (int k = 0; k < WIN; k++) sum_next[j] = sum_next[j] + SUM_W'(q_data.win[j][k]);
    end
  end

  always_comb begin
    logic signed [TERM_W:0] dn, db;
    for (int j = 0; j < LANES; j++) begin
      for (int k = 0; k < WIN; k++) begin
        dn = $signed({1'b0, TERM_W'({win_a[j][k], 3'b000})})
           - $signed({1'b0, TERM_W'(PAT_NORMAL[k]) * TERM_W'(sum_a[j])});
        db = $signed({1'b0, TERM_W'({win_a[j][k], 3'b000})})
           - $signed({1'b0, TERM_W'(PAT_BR[k]) * TERM_W'(sum_a[j])});
        tn_next[j][k] = dn[TERM_W] ? TERM_W'(-dn) : dn[TERM_W-1:0];
        tb_next[j][k] = db[TERM_W] ? TERM_W'(-db) : db[TERM_W-1:0];
      end
    end
  end

  always_comb begin
    logic [ERR_W-1:0] en_sum, eb_sum;
    logic [CMP_W-1:0] lim;
    for (int j = 0; j < LANES; j++) begin
      en_sum = '0;
      eb_sum = '0;
      for (int k = 0; k < WIN; k++) begin
        en_sum = en_sum + ERR_W'(tn_b[j][k]);
        eb_sum = eb_sum + ERR_W'(tb_b[j][k]);
      end
      lim        = CMP_W'(sum_b[j]) << 4;
      mn_next[j] = (sum_b[j] != '0)
                && (((CMP_W'(en_sum) << 2) + CMP_W'(en_sum)) < lim);
      mb_next[j] = (sum_b[j] != '0)
                && (((CMP_W'(eb_sum) << 2) + CMP_W'(eb_sum)) < lim);
    end
    // Disagreement above 30 percent: 10*D > 3*L.
    dis_next = ((12'(meta_b.dis) << 3) + (12'(meta_b.dis) << 1))
             > ((12'(meta_b.pos) << 1) + 12'(meta_b.pos));
  end

  // Keep the first matching window per lane; normal wins over bottom-right.
  always_comb begin
    logic [SEEN_W-1:0] n_norm, n_br;
    n_norm = '0;
    n_br   = '0;
    for (int j = 0; j < LANES; j++) begin
      found_eff[j] = found[j];
      if (found[j] == TYPE_NONE && meta_c.check[j]) begin
        priority if (mn_c[j]) found_eff[j] = TYPE_NORMAL;
        else if (mb_c[j])     found_eff[j] = TYPE_CORNER;
        else                  found_eff[j] = found[j];
      end
      if (found_eff[j] == TYPE_NORMAL) n_norm = n_norm + SEEN_W'(1);
      if (found_eff[j] == TYPE_CORNER) n_br   = n_br + SEEN_W'(1);
    end
    anchor_next = TYPE_NONE;
    cause_next  = CAUSE_OK;
    priority if (dis_c)                       cause_next = CAUSE_DISAGREE;
    else if (meta_c.few_runs)                 cause_next = CAUSE_FEW_RUNS;
    else if (n_norm >= SEEN_W'(VOTE_MIN))     anchor_next = TYPE_NORMAL;
    else if (n_br >= SEEN_W'(VOTE_MIN))       anchor_next = TYPE_CORNER;
    else                                      cause_next = CAUSE_VOTE;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      meta_a <= q_data.meta;
      win_a  <= q_data.win;
      sum_a  <= sum_next;
      meta_b <= meta_a;
      sum_b  <= sum_a;
      tn_b   <= tn_next;
      tb_b   <= tb_next;
      meta_c <= meta_b;
      dis_c  <= dis_next;
      mn_c   <= mn_next;
      mb_c   <= mb_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      va_b      <= 1'b0;
      vc        <= 1'b0;
      out_valid <= 1'b0;
      for (int j = 0; j < LANES; j++) found[j] <= TYPE_NONE;
    end else begin
      if (en) begin
        va   <= q_pop;
        va_b <= va;
        vc   <= va_b;
        if (vc) begin
          for (int j = 0; j < LANES; j++)
            found[j] <= meta_c.last ? TYPE_NONE : found_eff[j];
        end
      end
      priority if (en && vc && meta_c.last) out_valid <= 1'b1;
      else if (!out_stall)                  out_valid <= 1'b0;
      else                                  out_valid <= out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && vc && meta_c.last) begin
      anchor_type  <= anchor_next;
      reject_cause <= cause_next;
    end
  end

endmodule

// ----- src/finder_pattern_band_classifier.sv -----
// Top level of the finder pattern band classifier.
//
// Input channel: one beat per scan position, five lane pixels and last_sample.
// A beat is taken at a clock edge with in_valid high and in_stall low. Each
// lane is thresholded above 127, run-length encoded, and its last five runs
// are tested against the 1:1:4:1:1 and 1:2:2:2:1 ratios.
// Output channel: one beat per scan line, anchor_type and reject_cause,
// taken at an edge with out_valid high and out_stall low. A line also ends
// at its 64th position when last_sample has not come.
// Throughput: one position per cycle while in_stall is low. The front end
// feeds a four-deep queue; a three-stage ratio test pipeline and the result
// register follow it. The result of a line passes through the queue, stages
// A, B and C and the result register after its last position is taken.
// While out_stall holds a waiting result, the back end holds too; the queue
// keeps taking positions until it fills, then in_stall rises.
// Reset clears the run state, the queue and all valid flags.
module finder_pattern_band_classifier (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] lane0_pixel,
  input  logic [7:0] lane1_pixel,
  input  logic [7:0] lane2_pixel,
  input  logic [7:0] lane3_pixel,
  input  logic [7:0] lane4_pixel,
  input  logic       last_sample,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] anchor_type,
  output logic [1:0] reject_cause
);
  import fpb_pkg::*;

  logic                         accept;
  logic [LANES-1:0][PIX_W-1:0]  pixel;
  fpb_beat_t                    beat, q_data;
  logic                         q_full, q_avail, q_pop;

  assign pixel  = {lane4_pixel, lane3_pixel, lane2_pixel, lane1_pixel, lane0_pixel};
  assign accept = in_valid && !q_full;
  assign in_stall = q_full;

  fpb_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .pixel       (pixel),
    .last_sample (last_sample),
    .beat        (beat)
  );

  fpb_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept),
    .wr_data (beat),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .avail   (q_avail)
  );

  fpb_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_data       (q_data),
    .q_avail      (q_avail),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .anchor_type  (anchor_type),
    .reject_cause (reject_cause)
  );

endmodule

// ----- tb/finder_pattern_band_classifier_test.sv -----
// Self-checking testbench for the finder pattern band classifier.
module finder_pattern_band_classifier_test;
  import fpb_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_POSITIONS  = 96;

  typedef logic [LANES-1:0][PIX_W-1:0] band_t;

  typedef struct packed {
    anchor_t anchor;
    cause_t  cause;
  } verdict_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] lane0_pixel = '0;
  logic [7:0] lane1_pixel = '0;
  logic [7:0] lane2_pixel = '0;
  logic [7:0] lane3_pixel = '0;
  logic [7:0] lane4_pixel = '0;
  logic       last_sample = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] anchor_type;
  logic [1:0] reject_cause;

  finder_pattern_band_classifier u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .lane0_pixel  (lane0_pixel),
    .lane1_pixel  (lane1_pixel),
    .lane2_pixel  (lane2_pixel),
    .lane3_pixel  (lane3_pixel),
    .lane4_pixel  (lane4_pixel),
    .last_sample  (last_sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .anchor_type  (anchor_type),
    .reject_cause (reject_cause)
  );

  always #4 clk = ~clk;

  int idle_pct = 0;
  int stall_pct = 0;
  int positions_sent = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  verdict_t verdicts_due [$];

  // Predicted line state.
  logic             open_color [LANES];
  logic [RUN_W-1:0] open_len [LANES];
  window_t          recent_runs [LANES];
  logic [WIN-1:0]   recent_colors [LANES];
  logic [SEEN_W-1:0] runs_seen [LANES];
  anchor_t          lane_anchor [LANES];
  logic [CNT_W-1:0] mixed_positions;
  logic [CNT_W-1:0] line_positions;

  // Line under construction: one color vector per position, 1 = white.
  logic [LANES-1:0] line_cols [MAX_POSITIONS];
  int               line_len;

  function automatic void clear_line_state();
    for (int j = 0; j < LANES; j++) begin
      open_color[j]    = 1'b0;
      open_len[j]      = '0;
      recent_runs[j]   = '0;
      recent_colors[j] = '0;
      runs_seen[j]     = '0;
      lane_anchor[j]   = TYPE_NONE;
    end
    mixed_positions = '0;
    line_positions  = '0;
  endfunction

  // Exact ratio test: 5 * sum|8*a - b*S| < 16 * S.
  function automatic logic ratio_fits(window_t w, anchor_t kind);
    int total;
    int err;
    int d;
    int p;
    total = 0;
    err = 0;
    for (int k = 0; k < WIN; k++) total += int'(w[k]);
    if (total == 0) return 1'b0;
    for (int k = 0; k < WIN; k++) begin
      p = (kind == TYPE_NORMAL) ? int'(PAT_NORMAL[k]) : int'(PAT_BR[k]);
      d = 8 * int'(w[k]) - p * total;
      err += (d < 0) ? -d : d;
    end
    return (5 * err < 16 * total);
  endfunction

  function automatic void close_run(int lane, logic [RUN_W-1:0] len, logic color);
    for (int k = 0; k < WIN - 1; k++) begin
      recent_runs[lane][k]   = recent_runs[lane][k+1];
      recent_colors[lane][k] = recent_colors[lane][k+1];
    end
    recent_runs[lane][WIN-1]   = len;
    recent_colors[lane][WIN-1] = color;
    if (runs_seen[lane] != SEEN_MAX) runs_seen[lane]++;
    // Only the first matching window that opens on white counts.
    if (runs_seen[lane] >= WIN && lane_anchor[lane] == TYPE_NONE &&
        recent_colors[lane][0]) begin
      if (ratio_fits(recent_runs[lane], TYPE_NORMAL)) lane_anchor[lane] = TYPE_NORMAL;
      else if (ratio_fits(recent_runs[lane], TYPE_CORNER)) lane_anchor[lane] = TYPE_CORNER;
    end
  endfunction

  function automatic void predict_position(band_t px, logic last);
    logic     col [LANES];
    logic     mixed;
    logic     line_end;
    int       votes [3];
    verdict_t v;
    mixed = 1'b0;
    for (int j = 0; j < LANES; j++) col[j] = (px[j] > 8'd127);
    line_end = last || (int'(line_positions) + 1 >= MAX_LINE_LENGTH);
    for (int j = 0; j < LANES; j++) begin
      if (col[j] != col[0]) mixed = 1'b1;
      if (line_positions == 0) begin
        open_color[j] = col[j];
        open_len[j]   = RUN_W'(1);
      end else if (col[j] == open_color[j]) begin
        if (open_len[j] != RUN_MAX) open_len[j]++;
      end else begin
        close_run(j, open_len[j], open_color[j]);
        open_len[j]   = RUN_W'(1);
        open_color[j] = col[j];
      end
    end
    if (mixed && mixed_positions != CNT_MAX) mixed_positions++;
    if (line_positions != CNT_MAX) line_positions++;
    if (!line_end) return;

    // Append the open run only when it is longer than one.
    for (int j = 0; j < LANES; j++)
      if (open_len[j] > 1) close_run(j, open_len[j], open_color[j]);

    v.anchor = TYPE_NONE;
    v.cause  = CAUSE_OK;
    votes = '{0, 0, 0};
    if (10 * int'(mixed_positions) > 3 * int'(line_positions)) begin
      v.cause = CAUSE_DISAGREE;
    end else begin
      for (int j = 0; j < LANES; j++)
        if (runs_seen[j] < WIN) v.cause = CAUSE_FEW_RUNS;
      if (v.cause == CAUSE_OK) begin
        for (int j = 0; j < LANES; j++) votes[int'(lane_anchor[j])]++;
        if (votes[int'(TYPE_NORMAL)] >= VOTE_MIN) v.anchor = TYPE_NORMAL;
        else if (votes[int'(TYPE_CORNER)] >= VOTE_MIN) v.anchor = TYPE_CORNER;
        else v.cause = CAUSE_VOTE;
      end
    end
    verdicts_due = {verdicts_due, v};
    clear_line_state();
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
  endtask

  // Observe both channels at the rising edge: check results, then predict.
  always @(posedge clk) begin : observe
    verdict_t due;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (verdicts_due.size() == 0) begin
          report_mismatch("unexpected result, anchor_type", int'(anchor_type), -1);
        end else begin
          due = verdicts_due.pop_front();
          if (anchor_type !== due.anchor)
            report_mismatch("anchor_type", int'(anchor_type), int'(due.anchor));
          if (reject_cause !== due.cause)
            report_mismatch("reject_cause", int'(reject_cause), int'(due.cause));
        end
      end
      if (in_valid && !in_stall)
        predict_position({lane4_pixel, lane3_pixel, lane2_pixel, lane1_pixel, lane0_pixel},
                         last_sample);
    end
  end

  always @(negedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_position(band_t px, logic last);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    lane0_pixel <= px[0];
    lane1_pixel <= px[1];
    lane2_pixel <= px[2];
    lane3_pixel <= px[3];
    lane4_pixel <= px[4];
    last_sample <= last;
    // Hold the beat until it is taken.
    do @(posedge clk); while (in_stall);
    positions_sent++;
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
  endtask

  task automatic send_line(logic mark_last);
    band_t px;
    for (int p = 0; p < line_len; p++) begin
      for (int j = 0; j < LANES; j++)
        px[j] = line_cols[p][j] ? PIX_W'($urandom_range(128, 255))
                                : PIX_W'($urandom_range(0, 127));
      send_position(px, mark_last && (p == line_len - 1));
    end
  endtask

  // Lead run, five pattern runs scaled by unit, trail run; lanes may be
  // jittered, swapped to another pattern, or have single pixels flipped.
  task automatic build_finder_line(anchor_t kind, int unit, int lead, int trail,
                                   logic lead_white, int jitter_pct, int swap_pct,
                                   int flip_pct);
    int      runs [7];
    int      p;
    int      pv;
    anchor_t lane_kind;
    logic    color;
    line_len = lead + 8 * unit + trail;
    for (int j = 0; j < LANES; j++) begin
      lane_kind = kind;
      if ($urandom_range(99) < swap_pct) lane_kind = anchor_t'($urandom_range(2));
      runs[0] = lead;
      runs[6] = trail;
      for (int k = 0; k < WIN; k++) begin
        if (lane_kind == TYPE_NONE) pv = $urandom_range(1, 6);
        else if (lane_kind == TYPE_NORMAL) pv = int'(PAT_NORMAL[k]) * unit;
        else pv = int'(PAT_BR[k]) * unit;
        runs[k+1] = pv;
      end
      for (int r = 0; r < 7; r++)
        if ($urandom_range(99) < jitter_pct) begin
          if ($urandom_range(1) == 1) runs[r]++;
          else if (runs[r] > 1) runs[r]--;
        end
      p = 0;
      color = lead_white;
      for (int r = 0; r < 7; r++) begin
        for (int n = 0; n < runs[r]; n++) begin
          if (p < line_len) line_cols[p][j] = color;
          p++;
        end
        color = ~color;
      end
      // Pad a short lane with its trailing color.
      for (; p < line_len; p++) line_cols[p][j] = ~color;
    end
    for (int q = 0; q < line_len; q++)
      for (int j = 0; j < LANES; j++)
        if ($urandom_range(99) < flip_pct) line_cols[q][j] = ~line_cols[q][j];
  endtask

  task automatic build_noise_line(int len);
    logic shared;
    shared = 1'($urandom_range(1));
    line_len = len;
    for (int p = 0; p < len; p++) begin
      if ($urandom_range(99) < 30) shared = ~shared;
      for (int j = 0; j < LANES; j++)
        line_cols[p][j] = ($urandom_range(99) < 20) ? ~shared : shared;
    end
  endtask

  task automatic test_pixel_extremes();
    send_position({8'd0, 8'd255, 8'd128, 8'd127, 8'd0}, 1'b1);
    send_position({5{8'd255}}, 1'b1);
    send_position({5{8'd127}}, 1'b0);
    send_position({5{8'd0}}, 1'b1);
    send_position({5{8'd128}}, 1'b0);
    send_position({8'd255, 8'd0, 8'd255, 8'd0, 8'd255}, 1'b1);
    wait_for_results();
  endtask

  task automatic test_reference_patterns();
    build_finder_line(TYPE_NORMAL, 1, 1, 2, 1'b0, 0, 0, 0);
    send_line(1'b1);
    build_finder_line(TYPE_CORNER, 1, 1, 2, 1'b0, 0, 0, 0);
    send_line(1'b1);
    wait_for_results();
  endtask

  // A line ends at its last allowed position even without last_sample.
  task automatic test_overlong_lines();
    build_noise_line(MAX_LINE_LENGTH);
    send_line(1'b0);
    build_noise_line(MAX_LINE_LENGTH + 6);
    send_line(1'b1);
    build_finder_line(TYPE_NORMAL, 7, 3, 4, 1'b0, 0, 0, 0);
    send_line(1'b1);
    wait_for_results();
  endtask

  task automatic test_random_lines(int idle, int stall, int count);
    int goal;
    int pick;
    idle_pct  = idle;
    stall_pct = stall;
    goal = positions_sent + count;
    while (positions_sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 72) begin
        build_finder_line(anchor_t'($urandom_range(1, 2)), $urandom_range(1, 5),
                          $urandom_range(1, 3), $urandom_range(2, 4),
                          ($urandom_range(4) == 0),
                          ($urandom_range(1) == 1) ? 0 : 10 * $urandom_range(1, 3),
                          ($urandom_range(2) == 0) ? 0 : 15 * $urandom_range(1, 3),
                          ($urandom_range(1) == 1) ? 0 : 3 * $urandom_range(1, 3));
      end else begin
        build_noise_line($urandom_range(1, 80));
      end
      // Occasionally leave the line open so it runs into the next one.
      send_line($urandom_range(9) != 0);
    end
    wait_for_results();
  endtask

  initial begin
    clear_line_state();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_pixel_extremes();
    test_reference_patterns();
    test_overlong_lines();
    test_random_lines(0, 0, 260);
    test_random_lines(61, 0, 260);
    test_random_lines(0, 61, 260);
    test_random_lines(31, 31, 260);
    stall_pct = 0;
    wait_for_results();
    repeat (16) @(posedge clk);
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
